[rtl/rklf_pkg.sv]
// Shared types, constants and the fixed key-position map of the reactive LED fader.
package rklf_pkg;

  localparam int LED_COUNT      = 28;
  localparam int POSITION_COUNT = 44;
  localparam int LED_W          = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int MAP_ENTRIES    = 44;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int QUOT_W = 8;
  localparam int STEP_W = $clog2(QUOT_W);

  localparam logic [7:0]  FULL_LEVEL = 8'd255;
  localparam logic [15:0] FADE_RESET = 16'd400;
  localparam logic [4:0]  DARK_RESET = 5'd6;

  localparam logic MODE_KEY  = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [0:0] {
    REG_FADE_MS   = 1'b0,
    REG_DARK_LEDS = 1'b1
  } reg_index_t;

  typedef enum logic [0:0] {
    CMD_STAMP  = 1'b0,
    CMD_RENDER = 1'b1
  } cmd_kind_t;

  typedef struct packed {
    logic        mode;
    logic [5:0]  key_position;
    logic        pressed;
    logic        local_source;
    logic [31:0] now_ms;
  } req_t;

  typedef struct packed {
    logic [4:0] led_index;
    logic [7:0] level;
    logic       last;
    logic       still_active;
  } led_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [4:0]  led;
    logic [31:0] now_ms;
  } cmd_t;

  typedef struct packed {
    logic [15:0] fade_ms;
    logic [4:0]  dark_leds;
  } cfg_t;

  localparam logic [4:0] FIXED_MAP [0:MAP_ENTRIES-1] = '{
    5'd6,  5'd7,  5'd8,  5'd9,  5'd10, 5'd11, 5'd12, 5'd12, 5'd11, 5'd10, 5'd9,
    5'd8,  5'd7,  5'd6,  5'd13, 5'd14, 5'd15, 5'd16, 5'd17, 5'd18, 5'd18, 5'd17,
    5'd16, 5'd15, 5'd14, 5'd13, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd24,
    5'd23, 5'd22, 5'd21, 5'd20, 5'd19, 5'd25, 5'd26, 5'd27, 5'd27, 5'd26, 5'd25
  };

  // Positions past the fixed table map to LED 0.
  function automatic logic [4:0] map_position(input logic [5:0] pos);
    logic [4:0] led;
    led = 5'd0;
    if (7'(pos) < 7'(MAP_ENTRIES)) begin
      led = FIXED_MAP[pos];
    end
    return led;
  endfunction

endpackage

[rtl/rklf_front.sv]
// Front end: accepts items, drops ignored key events and queues stamp or render commands.
module rklf_front (
  input  logic          req_valid,
  output logic          req_stall,
  input  rklf_pkg::req_t req,
  input  logic          queue_full,
  output logic          push,
  output rklf_pkg::cmd_t push_cmd
);

  logic [4:0] map_led;
  logic       is_stamp;
  logic       is_tick;

  assign map_led = rklf_pkg::map_position(req.key_position);

  // A press from our own scanner at a mapped position that lands on a real LED.
  assign is_stamp = (req.mode == rklf_pkg::MODE_KEY) && req.pressed && req.local_source
                 && (7'(req.key_position) < 7'(rklf_pkg::POSITION_COUNT))
                 && (7'(map_led) < 7'(rklf_pkg::LED_COUNT));
  assign is_tick  = (req.mode == rklf_pkg::MODE_TICK);

  assign req_stall = queue_full;
  assign push      = req_valid && !queue_full && (is_stamp || is_tick);

  always_comb begin
    push_cmd.kind   = is_tick ? rklf_pkg::CMD_RENDER : rklf_pkg::CMD_STAMP;
    push_cmd.led    = map_led;
    push_cmd.now_ms = req.now_ms;
  end

endmodule

[rtl/rklf_queue.sv]
// Short command queue between the front end and the render engine.
module rklf_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  rklf_pkg::cmd_t        push_cmd,
  output logic                  full,
  input  logic                  pop,
  output logic                  valid,
  output rklf_pkg::cmd_t        head
);

  rklf_pkg::cmd_t                slots [rklf_pkg::QUEUE_DEPTH];
  logic [rklf_pkg::QPTR_W-1:0]   wr_ptr;
  logic [rklf_pkg::QPTR_W-1:0]   rd_ptr;
  logic [rklf_pkg::QCNT_W-1:0]   count;

  assign full  = (count == rklf_pkg::QCNT_W'(rklf_pkg::QUEUE_DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

[rtl/rklf_back.sv]
// Render engine: applies stamps and walks the LEDs with a bit-serial divider per tick.
module rklf_back (
  input  logic           clk,
  input  logic           rst,
  input  rklf_pkg::cfg_t cfg,
  input  logic           cmd_valid,
  input  rklf_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           led_valid,
  input  logic           led_stall,
  output rklf_pkg::led_t led
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SUB,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t                         state;
  logic [31:0]                    stamp_mem [rklf_pkg::LED_COUNT];
  logic [31:0]                    stamp_rd;
  logic [rklf_pkg::LED_COUNT-1:0] fading;
  logic [rklf_pkg::LED_W-1:0]     idx;
  logic [rklf_pkg::LED_W-1:0]     cmd_led;
  logic [31:0]                    now_ms;
  logic [31:0]                    dt;
  logic [15:0]                    rem;
  logic [7:0]                     div_low;
  logic [7:0]                     quot;
  logic [rklf_pkg::STEP_W-1:0]    step;
  logic [7:0]                     level;
  logic                           fade_seen;

  logic                           is_last;
  logic                           lit;
  logic [23:0]                    scaled;
  logic [16:0]                    trial;
  logic [16:0]                    trial_sub;
  logic                           out_free;
  logic                           stamp_wr;

  assign cmd_led   = rklf_pkg::LED_W'(cmd.led);
  assign is_last   = (idx == rklf_pkg::LED_W'(rklf_pkg::LED_COUNT - 1));
  assign lit       = fading[idx] && (7'(idx) >= 7'(cfg.dark_leds));
  // dt * 255 as a shift and subtract; only the low 16 bits of dt matter once dt < fade_ms.
  assign scaled    = {dt[15:0], 8'd0} - {8'd0, dt[15:0]};
  assign trial     = {rem, div_low[7]};
  assign trial_sub = trial - {1'b0, cfg.fade_ms};
  assign out_free  = !led_valid || !led_stall;
  assign cmd_pop   = (state == ST_IDLE) && cmd_valid;
  assign stamp_wr  = cmd_pop && (cmd.kind == rklf_pkg::CMD_STAMP);

  always_ff @(posedge clk) begin
    if (stamp_wr) begin
      stamp_mem[cmd_led] <= cmd.now_ms;
    end
    if (state == ST_READ) begin
      stamp_rd <= stamp_mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      fading     <= '0;
      led_valid  <= 1'b0;
      idx        <= '0;
      fade_seen  <= 1'b0;
    end else begin
      // In ST_EMIT a taken item is replaced by the next one instead.
      if (led_valid && !led_stall && (state != ST_EMIT)) begin
        led_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            unique case (cmd.kind)
              rklf_pkg::CMD_STAMP: begin
                fading[cmd_led] <= 1'b1;
              end
              rklf_pkg::CMD_RENDER: begin
                now_ms     <= cmd.now_ms;
                idx        <= '0;
                fade_seen  <= 1'b0;
                state      <= ST_READ;
              end
              default: state <= ST_IDLE;
            endcase
          end
        end
        ST_READ: begin
          state <= ST_SUB;
        end
        ST_SUB: begin
          dt    <= now_ms - stamp_rd;
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          level <= 8'd0;
          if (!lit) begin
            state <= ST_EMIT;
          end else if (dt >= {16'd0, cfg.fade_ms}) begin
            fading[idx] <= 1'b0;
            state       <= ST_EMIT;
          end else begin
            rem     <= scaled[23:8];
            div_low <= scaled[7:0];
            quot    <= 8'd0;
            step    <= '0;
            state   <= ST_DIV;
          end
        end
        ST_DIV: begin
          // One restoring-division step per cycle; the quotient fits in eight bits.
          if (!trial_sub[16]) begin
            rem <= trial_sub[15:0];
          end else begin
            rem <= trial[15:0];
          end
          div_low <= {div_low[6:0], 1'b0};
          quot    <= {quot[6:0], !trial_sub[16]};
          step    <= step + 1'b1;
          if (step == rklf_pkg::STEP_W'(rklf_pkg::QUOT_W - 1)) begin
            level      <= rklf_pkg::FULL_LEVEL - {quot[6:0], !trial_sub[16]};
            fade_seen  <= 1'b1;
            state      <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            led_valid        <= 1'b1;
            led.led_index    <= 5'(idx);
            led.level        <= level;
            led.last         <= is_last;
            led.still_active <= is_last && fade_seen;
            if (is_last) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx + 1'b1;
              state <= ST_READ;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[rtl/reactive_key_led_fader_top.sv]
// Top level of the reactive LED fader: configuration registers and the front/queue/back chain.
// With an idle back end a key event is applied as the back end pops it from the queue, and
// a render tick gives its first LED item after the read, subtract and check states of LED 0.
// Each LED passes through read, subtract, check and emit states, a fading LED also through the
// 8-step serial divider; a stalled output holds emit, and the next command waits for the walk.
// Reset clears queue, fading bits and output valid; sets fade_ms 400 and dark_leds 6.
module reactive_key_led_fader_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  rklf_pkg::req_t req,
  output logic           led_valid,
  input  logic           led_stall,
  output rklf_pkg::led_t led,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [2:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready
);

  rklf_pkg::cfg_t cfg;
  logic           cfg_write;
  logic           queue_full;
  logic           push;
  rklf_pkg::cmd_t push_cmd;
  logic           cmd_valid;
  logic           cmd_pop;
  rklf_pkg::cmd_t cmd;

  // The bus never waits; registers decode on address bit 2 alone.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fade_ms   <= rklf_pkg::FADE_RESET;
      cfg.dark_leds <= rklf_pkg::DARK_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        rklf_pkg::REG_FADE_MS:   cfg.fade_ms   <= pwdata[15:0];
        rklf_pkg::REG_DARK_LEDS: cfg.dark_leds <= pwdata[4:0];
        default:                 cfg.fade_ms   <= cfg.fade_ms;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      rklf_pkg::REG_FADE_MS:   prdata = {16'd0, cfg.fade_ms};
      rklf_pkg::REG_DARK_LEDS: prdata = {27'd0, cfg.dark_leds};
      default:                 prdata = 32'd0;
    endcase
  end

  // The front end sorts items: ignored key events are taken and dropped, useful
  // ones become commands in the queue, which stalls the input only when full.
  rklf_front u_front (
    .req_valid  (req_valid),
    .req_stall  (req_stall),
    .req        (req),
    .queue_full (queue_full),
    .push       (push),
    .push_cmd   (push_cmd)
  );

  rklf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (queue_full),
    .pop      (cmd_pop),
    .valid    (cmd_valid),
    .head     (cmd)
  );

  // The back end runs one command at a time; its output register lets the LED
  // walk continue while the previous item still waits to be taken.
  rklf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .led_valid (led_valid),
    .led_stall (led_stall),
    .led       (led)
  );

endmodule

[rtl/rklf_checker.sv]
// Port-level checker for the reactive LED fader and its bind to the top level.
module rklf_checker (
  input logic           clk,
  input logic           rst,
  input logic           led_valid,
  input logic           led_stall,
  input rklf_pkg::led_t led
);

  a_reset_clears_output: assert property (@(posedge clk) rst |=> !led_valid)
    else $error("LED output valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    led_valid && led_stall |=> led_valid && $stable(led))
    else $error("stalled LED item changed");

  a_active_only_on_last: assert property (@(posedge clk) disable iff (rst)
    led_valid && !led.last |-> !led.still_active)
    else $error("still_active flagged before the last LED");

  a_last_at_chain_end: assert property (@(posedge clk) disable iff (rst)
    led_valid && led.last |-> led.led_index == 5'(rklf_pkg::LED_COUNT - 1))
    else $error("last flag on an LED other than the final one");

endmodule

bind reactive_key_led_fader_top rklf_checker u_rklf_checker (
  .clk       (clk),
  .rst       (rst),
  .led_valid (led_valid),
  .led_stall (led_stall),
  .led       (led)
);
